/* rtl/core/sliding_window_median_filter_macros.svh */
// Assertion macros shared by the median filter RTL.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/swmf_pkg.sv */
// Shared types and constants of the sliding window median filter.
package swmf_pkg;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int MEDIAN_W = 32;

  // Operation carried by an input word
  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_PRESET = 2'd1,
    OP_ADD    = 2'd2
  } op_e;

  // Per-cycle command broadcast to every history cell
  typedef struct packed {
    logic shift;   // take the neighbour's value (new sample enters cell 0)
    logic preset;  // load the common level
    logic add;     // add the offset, saturating
  } cell_ctrl_t;

endpackage

/* rtl/core/swmf_if.sv */
// Valid/ready channel interfaces for input and result words.
interface swmf_in_if;
  import swmf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface swmf_out_if;
  import swmf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median;
  logic                       window_full;

  modport source (output valid, output median, output window_full, input ready);
  modport sink   (input valid, input median, input window_full, output ready);
endinterface

/* rtl/core/swmf_cell.sv */
// One history cell: holds a sample, shifts, presets or adds a saturated offset.
module swmf_cell #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swmf_pkg::cell_ctrl_t              ctrl_i,
  input  logic        [SAMPLE_WIDTH-1:0]    shift_in_i,
  input  logic        [SAMPLE_WIDTH-1:0]    level_i,
  input  logic signed [swmf_pkg::VALUE_W-1:0] offset_i,
  output logic        [SAMPLE_WIDTH-1:0]    value_o
);
  import swmf_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int SUMW = ((SW > VALUE_W) ? SW : VALUE_W) + 1;
  localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SMIN = {{(SUMW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  logic signed [SW-1:0]   value_q, value_d;
  logic signed [SUMW-1:0] sum;
  logic signed [SW-1:0]   sat;

  // Saturating add of the offset
  always_comb begin
    sum = SUMW'(value_q) + SUMW'(offset_i);
    if (sum > SMAX) begin
      sat = SMAX[SW-1:0];
    end else if (sum < SMIN) begin
      sat = SMIN[SW-1:0];
    end else begin
      sat = sum[SW-1:0];
    end
  end

  // Next value
  always_comb begin
    priority if (ctrl_i.shift) begin
      value_d = shift_in_i;
    end else if (ctrl_i.preset) begin
      value_d = level_i;
    end else if (ctrl_i.add) begin
      value_d = sat;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

/* rtl/core/swmf_order.sv */
// Pairwise order matrix over the window: which entries rank below each entry.
module swmf_order #(
  parameter int WINDOW       = 5,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic [WINDOW-1:0][SAMPLE_WIDTH-1:0] vals_i,
  output logic [WINDOW-1:0][WINDOW-1:0]       lt_o
);
  import swmf_pkg::*;

  // lt_o[i][j]: entry j sorts before entry i; ties broken by index
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        if (j < i) begin
          lt_o[i][j] = $signed(vals_i[j]) <= $signed(vals_i[i]);
        end else if (j > i) begin
          lt_o[i][j] = $signed(vals_i[j]) < $signed(vals_i[i]);
        end else begin
          lt_o[i][j] = 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/core/swmf_pick.sv */
// Rank count per entry and selection of the middle-ranked entry.
module swmf_pick #(
  parameter int WINDOW       = 5,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic [WINDOW-1:0][WINDOW-1:0]       lt_i,
  input  logic [WINDOW-1:0][SAMPLE_WIDTH-1:0] vals_i,
  output logic [SAMPLE_WIDTH-1:0]             median_o
);
  import swmf_pkg::*;

  localparam int RW  = $clog2(WINDOW);
  localparam int MID = (WINDOW - 1) / 2;

  logic [WINDOW-1:0] hit;

  // Rank of each entry; ranks form a permutation, so exactly one hits
  always_comb begin
    logic [RW-1:0] cnt;
    for (int i = 0; i < WINDOW; i++) begin
      cnt = '0;
      for (int j = 0; j < WINDOW; j++) begin
        cnt = cnt + RW'(lt_i[i][j]);
      end
      hit[i] = (cnt == RW'(MID));
    end
  end

  // One-hot select
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW; i++) begin
      median_o = median_o | (vals_i[i] & {SAMPLE_WIDTH{hit[i]}});
    end
  end

endmodule

/* rtl/core/sliding_window_median_filter.sv */
// Top level of the sliding window median filter.
//
//  channel | dir | fields              | word
//  --------+-----+---------------------+-------------------------------------
//  in_i    | in  | opcode, value       | sample, preset level or offset
//  out_o   | out | median, window_full | one per sample word
//
// One input word per clock while in_i.ready is high; the cell row updates
// every history slot in the cycle the word is taken. A sample's median
// passes the compare matrix register, rank/select, then the output register.
// Reset (asynchronous) zeroes all cells, the slot counter and the valid flags.
// Stalls: empty stages close up, so input is taken while a result waits; it
// is held off only while a pending sample cannot leave the compare stage.
`include "sliding_window_median_filter_macros.svh"

module sliding_window_median_filter #(
  parameter int WINDOW       = 5,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  swmf_in_if.sink         in_i,
  swmf_out_if.source      out_o
);
  import swmf_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int SUMW   = ((SW > VALUE_W) ? SW : VALUE_W) + 1;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SMIN = {{(SUMW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  logic                            accept;
  op_e                             op;
  cell_ctrl_t                      ctrl;
  logic signed [SUMW-1:0]          ext;
  logic signed [SW-1:0]            level;
  logic [WINDOW-1:0][SW-1:0]       vals;
  logic [WINDOW-1:0][WINDOW-1:0]   lt;
  logic signed [SW-1:0]            pick;
  logic signed [SUMW-1:0]          pick_ext;

  logic [SLOT_W-1:0]               slot_q, slot_d;
  logic                            filled_q, filled_d;

  logic                            p1_v_q, p2_v_q, out_v_q;
  logic                            p1_full_q, p2_full_q, full_q;
  logic [WINDOW-1:0][WINDOW-1:0]   p2_lt_q;
  logic [WINDOW-1:0][SW-1:0]       p2_vals_q;
  logic [MEDIAN_W-1:0]             median_q;
  logic                            out_rdy, p2_rdy, p1_rdy;

  // Handshake and decode
  assign accept = in_i.valid && in_i.ready;
  assign op     = op_e'(in_i.opcode);

  always_comb begin
    ctrl = '0;
    unique case (op)
      OP_SAMPLE: ctrl.shift  = accept;
      OP_PRESET: ctrl.preset = accept;
      OP_ADD:    ctrl.add    = accept;
      default:   ctrl        = '0;
    endcase
  end

  // Saturate the incoming value to the sample range
  always_comb begin
    ext = SUMW'(in_i.value);
    if (ext > SMAX) begin
      level = SMAX[SW-1:0];
    end else if (ext < SMIN) begin
      level = SMIN[SW-1:0];
    end else begin
      level = ext[SW-1:0];
    end
  end

  // Row of history cells; the oldest sample drops off the far end
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    logic [SW-1:0] shift_in;
    if (k == 0) begin : g_head
      assign shift_in = level;
    end else begin : g_link
      assign shift_in = vals[k-1];
    end
    swmf_cell #(
      .SAMPLE_WIDTH (SW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .shift_in_i (shift_in),
      .level_i    (level),
      .offset_i   (in_i.value),
      .value_o    (vals[k])
    );
  end

  // Fill counter and window-full flag
  always_comb begin
    slot_d   = slot_q;
    filled_d = filled_q;
    if (ctrl.shift) begin
      if (slot_q == SLOT_W'(WINDOW - 1)) begin
        slot_d   = '0;
        filled_d = 1'b1;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end else if (ctrl.preset) begin
      filled_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      filled_q <= 1'b0;
    end else begin
      slot_q   <= slot_d;
      filled_q <= filled_d;
    end
  end

  // Elastic pipeline control
  assign out_rdy    = !out_v_q || out_o.ready;
  assign p2_rdy     = !p2_v_q || out_rdy;
  assign p1_rdy     = !p1_v_q || p2_rdy;
  assign in_i.ready = p1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (p1_rdy) begin
        p1_v_q <= ctrl.shift;
      end
      if (p2_rdy) begin
        p2_v_q <= p1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= p2_v_q;
      end
    end
  end

  // Compare stage and output stage
  swmf_order #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SW)
  ) u_order (
    .vals_i (vals),
    .lt_o   (lt)
  );

  swmf_pick #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SW)
  ) u_pick (
    .lt_i     (p2_lt_q),
    .vals_i   (p2_vals_q),
    .median_o (pick)
  );

  assign pick_ext = SUMW'(pick);

  always_ff @(posedge clk_i) begin
    if (p1_rdy) begin
      p1_full_q <= filled_d;
    end
    if (p2_rdy) begin
      p2_lt_q   <= lt;
      p2_vals_q <= vals;
      p2_full_q <= p1_full_q;
    end
    if (out_rdy) begin
      median_q <= pick_ext[MEDIAN_W-1:0];
      full_q   <= p2_full_q;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.median      = median_q;
  assign out_o.window_full = full_q;

  // Checks
  `SWMF_ASSERT_NEXT(a_full_sticky, clk_i, rst_ni, filled_q, filled_q,
                    "window-full flag dropped")
  `SWMF_ASSERT_SAME(a_slot_range, clk_i, rst_ni, 1'b1, slot_q < SLOT_W'(WINDOW),
                    "slot counter out of range")
  `SWMF_ASSERT_NEXT(a_hold_cells, clk_i, rst_ni, p1_v_q && !p2_rdy, $stable(vals),
                    "history changed under a pending sample")
  `SWMF_ASSERT_SAME(a_out_source, clk_i, rst_ni, $rose(out_v_q), $past(p2_v_q),
                    "result word without a compare-stage word")

endmodule
